>>> hdl/mps_pkg.sv
// ---------------------------------------------------------------------------
// mps_pkg
// Shared constants, types and helpers for the melody playback sequencer.
// ---------------------------------------------------------------------------
package mps_pkg;

    localparam int NOTE_DEPTH_DEF = 64;

    localparam logic [2:0] M_IDLE     = 3'd0;
    localparam logic [2:0] M_PHRASE   = 3'd1;
    localparam logic [2:0] M_NOTE     = 3'd2;
    localparam logic [2:0] M_ON       = 3'd3;
    localparam logic [2:0] M_GAP      = 3'd4;
    localparam logic [2:0] M_PAUSED   = 3'd5;
    localparam logic [2:0] M_COMPLETE = 3'd6;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_PLAY    = 3'd1;
    localparam logic [2:0] CMD_PAUSE   = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_RESTART = 3'd4;
    localparam logic [2:0] CMD_WRITE   = 3'd5;

    localparam logic [2:0] REG_TONE_CLK  = 3'd0;
    localparam logic [2:0] REG_TICK_PER  = 3'd1;
    localparam logic [2:0] REG_GAP       = 3'd2;
    localparam logic [2:0] REG_PH_SETUP  = 3'd3;
    localparam logic [2:0] REG_NT_SETUP  = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE  = 3'd5;
    localparam logic [2:0] REG_SONG_LEN  = 3'd6;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [26:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [26:0] quotient;
    } t_div_rsp;

    function automatic logic [2:0] rgb_of_phrase(input logic [7:0] p);
        logic [15:0] prod;
        logic [7:0]  quo;
        logic [2:0]  m;
        // p mod 6: reciprocal multiply by 171/1024, exact for any 8-bit p
        prod = 16'(p) * 16'd171;
        quo  = 8'(prod[15:10]);
        m    = 3'(p - 8'(quo * 8'd6));
        case (m)
            3'd0:    rgb_of_phrase = 3'd1;
            3'd1:    rgb_of_phrase = 3'd4;
            3'd2:    rgb_of_phrase = 3'd2;
            3'd3:    rgb_of_phrase = 3'd5;
            3'd4:    rgb_of_phrase = 3'd6;
            default: rgb_of_phrase = 3'd3;
        endcase
    endfunction

    function automatic logic [3:0] bank_of_phrase(input logic [7:0] p);
        case (p)
            8'd0:    bank_of_phrase = 4'h5;
            8'd1:    bank_of_phrase = 4'hA;
            8'd2:    bank_of_phrase = 4'h0;
            8'd3:    bank_of_phrase = 4'hF;
            8'd4:    bank_of_phrase = 4'h5;
            default: bank_of_phrase = 4'hA;
        endcase
    endfunction

endpackage

>>> hdl/melody_playback_sequencer.sv
// ---------------------------------------------------------------------------
// melody_playback_sequencer
// Sequence: a request is decoded, then the note memory is read; a rewind
//   (stop, restart, start) or a gap end that moves to the next entry adds a
//   further read, a note-on tick adds the duration divide, a sounding note
//   adds the bit-serial tone divide.
// Throughput: one request in flight; the next one is accepted only after
//   the result has been taken.
// Reset: synchronous active low; control and registers to defaults, note
//   memory contents undefined until written.
// ---------------------------------------------------------------------------
module melody_playback_sequencer #(
    parameter int NOTE_DEPTH = mps_pkg::NOTE_DEPTH_DEF,
    localparam int AW = $clog2(NOTE_DEPTH)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // {note_phrase, note_duration_ms, note_frequency, note_address,
    //  switch_sample, command} from bit 0: command[2:0], switch_sample[3],
    //  note_address[9:4], note_frequency[25:10], duration[41:26], phrase[49:42]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // play_state[2:0], song_position[9:3], phrase_number[17:10],
    // rgb_pattern[20:18], bank_pattern[24:21], tone_enable[25],
    // tone_period[41:26], tone_compare[56:42]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // ---- config registers ----
    logic [26:0] r_tone_clk;
    logic [7:0]  r_tick_per, r_ph_setup, r_nt_setup;
    logic [15:0] r_gap;
    logic [3:0]  r_deb;
    logic [6:0]  r_song_len;
    logic [2:0]  reg_idx;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_clk <= 27'd16000000;
            r_tick_per <= 8'd5;
            r_gap      <= 16'd10;
            r_ph_setup <= 8'd1;
            r_nt_setup <= 8'd1;
            r_deb      <= 4'd3;
            r_song_len <= 7'd42;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                mps_pkg::REG_TONE_CLK: r_tone_clk <= pwdata[26:0];
                mps_pkg::REG_TICK_PER: r_tick_per <= pwdata[7:0];
                mps_pkg::REG_GAP:      r_gap      <= pwdata[15:0];
                mps_pkg::REG_PH_SETUP: r_ph_setup <= pwdata[7:0];
                mps_pkg::REG_NT_SETUP: r_nt_setup <= pwdata[7:0];
                mps_pkg::REG_DEBOUNCE: r_deb      <= pwdata[3:0];
                mps_pkg::REG_SONG_LEN: r_song_len <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mps_pkg::REG_TONE_CLK: prdata = {5'd0, r_tone_clk};
            mps_pkg::REG_TICK_PER: prdata = {24'd0, r_tick_per};
            mps_pkg::REG_GAP:      prdata = {16'd0, r_gap};
            mps_pkg::REG_PH_SETUP: prdata = {24'd0, r_ph_setup};
            mps_pkg::REG_NT_SETUP: prdata = {24'd0, r_nt_setup};
            mps_pkg::REG_DEBOUNCE: prdata = {28'd0, r_deb};
            mps_pkg::REG_SONG_LEN: prdata = {25'd0, r_song_len};
            default:               prdata = '0;
        endcase
    end

    // effective song length, clamped to memory depth
    logic [6:0] len;
    always_comb begin
        if (32'(r_song_len) > NOTE_DEPTH) len = 7'(NOTE_DEPTH);
        else                              len = r_song_len;
    end

    // ---- sequencer state ----
    localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_RD0W = 4'd2,
        S_CHK = 4'd3, S_DDUR = 4'd4, S_RDN = 4'd5, S_RDNW = 4'd6,
        S_ADV = 4'd7, S_RDP = 4'd8, S_RDPW = 4'd9, S_TONE = 4'd10,
        S_DTON = 4'd11, S_OUT = 4'd12, S_REW = 4'd13;

    logic [3:0]  r_st;
    logic [2:0]  r_mode, r_saved_mode;
    logic [6:0]  r_pos;
    logic [7:0]  r_phrase;
    logic [15:0] r_ticks, r_saved_ticks;
    logic        r_last, r_stable;
    logic [3:0]  r_cnt;
    logic [55:0] r_in;
    logic        r_timed;   // tick needs timed step after rewind read
    logic [63:0] r_out;
    logic        r_ovalid;
    logic [2:0]  r_rewind_mode;

    logic [2:0]  cmd;
    assign cmd = r_in[2:0];

    // memory
    logic          mem_we;
    logic [AW-1:0] mem_raddr, r_raddr;
    logic [39:0]   mem_rdata;
    logic [15:0]   rd_freq, rd_dur;
    logic [7:0]    rd_ph;
    assign rd_freq = mem_rdata[15:0];
    assign rd_dur  = mem_rdata[31:16];
    assign rd_ph   = mem_rdata[39:32];
    assign mem_raddr = r_raddr;
    assign mem_we = (r_st == S_RD0) && (cmd == mps_pkg::CMD_WRITE)
                    && (32'(r_in[9:4]) < NOTE_DEPTH);

    mps_note_mem #(.NOTE_DEPTH(NOTE_DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(AW'(r_in[9:4])),
        .i_wdata(r_in[49:10]),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    mps_pkg::t_div_req div_req;
    mps_pkg::t_div_rsp div_rsp;
    mps_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic r_div_go;
    logic [26:0] r_dvd;
    logic [15:0] r_dvs;
    assign div_req.start    = r_div_go;
    assign div_req.dividend = r_dvd;
    assign div_req.divisor  = r_dvs;

    function automatic logic active(input logic [2:0] m);
        active = (m == mps_pkg::M_PHRASE) || (m == mps_pkg::M_NOTE)
              || (m == mps_pkg::M_ON) || (m == mps_pkg::M_GAP);
    endfunction

    // debounce combinational on the captured sample
    logic       smp, deb_last, deb_stable, press_ev;
    logic [3:0] deb_cnt;
    always_comb begin
        smp = r_in[3];
        deb_last = r_last;
        deb_cnt = r_cnt;
        deb_stable = r_stable;
        press_ev = 1'b0;
        if (smp == r_last) begin
            if (r_cnt < r_deb) deb_cnt = r_cnt + 4'd1;
        end else begin
            deb_last = smp;
            deb_cnt = 4'd1;
        end
        if (deb_cnt >= r_deb && smp != r_stable) begin
            deb_stable = smp;
            press_ev = smp;
        end
    end

    logic [15:0] ticks_inc;
    assign ticks_inc = r_ticks + 16'd1;
    logic [7:0] per;
    assign per = (r_tick_per == 8'd0) ? 8'd1 : r_tick_per;
    logic [15:0] nt;
    assign nt = (div_rsp.quotient[15:0] == 16'd0) ? 16'd1 : div_rsp.quotient[15:0];
    logic [6:0] nxt;
    assign nxt = r_pos + 7'd1;
    logic [26:0] q;
    logic [15:0] period;
    always_comb begin
        q = div_rsp.quotient;
        if (q == 27'd0)             period = 16'd0;
        else if (q - 27'd1 > 27'hFFFF) period = 16'hFFFF;
        else                        period = 16'(q - 27'd1);
    end

    // rgb and bank patterns of the result from mode and phrase
    logic [3:0] bank;
    logic [2:0] rgb;
    always_comb begin
        rgb = 3'd0; bank = 4'd0;
        if (r_mode == mps_pkg::M_IDLE) begin
            rgb = 3'd2; bank = 4'h1;
        end else if (r_mode == mps_pkg::M_PAUSED) begin
            rgb = 3'd1; bank = 4'h8;
        end else if (r_mode == mps_pkg::M_COMPLETE) begin
            rgb = 3'd3; bank = 4'hF;
        end else if (active(r_mode)) begin
            rgb = mps_pkg::rgb_of_phrase(r_phrase);
            bank = mps_pkg::bank_of_phrase(r_phrase);
        end
    end

    logic        r_en;
    logic [15:0] r_period;

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_mode <= mps_pkg::M_IDLE;
            r_saved_mode <= mps_pkg::M_IDLE;
            r_pos <= '0;
            r_phrase <= '0;
            r_ticks <= '0;
            r_saved_ticks <= '0;
            r_last <= 1'b0;
            r_stable <= 1'b0;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
            r_timed <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_in <= s_axis_tdata;
                        r_st <= S_RD0;
                    end
                end
                S_RD0: begin
                    // decode command; rewind needs entry 0 phrase
                    r_timed <= 1'b0;
                    r_st <= S_CHK;
                    if (cmd == mps_pkg::CMD_TICK) begin
                        r_last <= deb_last; r_cnt <= deb_cnt; r_stable <= deb_stable;
                        r_timed <= 1'b1;
                        if (press_ev) begin
                            if (active(r_mode)) begin
                                r_saved_mode <= r_mode; r_saved_ticks <= r_ticks;
                                r_mode <= mps_pkg::M_PAUSED; r_ticks <= '0;
                            end else if (r_mode == mps_pkg::M_PAUSED) begin
                                r_mode <= r_saved_mode; r_ticks <= r_saved_ticks;
                            end else begin
                                r_rewind_mode <= mps_pkg::M_PHRASE;
                                r_raddr <= '0; r_st <= S_REW;
                            end
                        end
                    end else if (cmd == mps_pkg::CMD_PLAY) begin
                        if (r_mode == mps_pkg::M_PAUSED) begin
                            r_mode <= r_saved_mode; r_ticks <= r_saved_ticks;
                        end else if (r_mode == mps_pkg::M_IDLE
                                     || r_mode == mps_pkg::M_COMPLETE) begin
                            r_rewind_mode <= mps_pkg::M_PHRASE;
                            r_raddr <= '0; r_st <= S_REW;
                        end
                    end else if (cmd == mps_pkg::CMD_PAUSE) begin
                        if (active(r_mode)) begin
                            r_saved_mode <= r_mode; r_saved_ticks <= r_ticks;
                            r_mode <= mps_pkg::M_PAUSED; r_ticks <= '0;
                        end
                    end else if (cmd == mps_pkg::CMD_STOP) begin
                        r_rewind_mode <= mps_pkg::M_IDLE;
                        r_raddr <= '0; r_st <= S_REW;
                    end else if (cmd == mps_pkg::CMD_RESTART) begin
                        r_rewind_mode <= mps_pkg::M_PHRASE;
                        r_raddr <= '0; r_st <= S_REW;
                    end
                end
                S_REW: r_st <= S_RD0W;      // read issued
                S_RD0W: begin
                    r_pos <= '0; r_phrase <= rd_ph;
                    r_saved_mode <= mps_pkg::M_IDLE; r_saved_ticks <= '0;
                    r_mode <= r_rewind_mode; r_ticks <= '0;
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    // timed step for ticks
                    r_st <= S_RDP;
                    r_raddr <= AW'(r_pos);
                    if (r_timed && active(r_mode)) begin
                        r_timed <= 1'b0;
                        r_ticks <= ticks_inc;
                        unique case (r_mode)
                            mps_pkg::M_PHRASE:
                                if (ticks_inc >= 16'(r_ph_setup)) begin
                                    r_mode <= mps_pkg::M_NOTE; r_ticks <= '0;
                                end
                            mps_pkg::M_NOTE:
                                if (ticks_inc >= 16'(r_nt_setup)) begin
                                    r_mode <= mps_pkg::M_ON; r_ticks <= '0;
                                end
                            mps_pkg::M_ON:
                                if (r_pos < len) begin
                                    r_st <= S_RDN;  // read duration
                                end
                            default:
                                if (ticks_inc >= r_gap) begin
                                    if (nxt >= len) begin
                                        r_pos <= len;
                                        r_mode <= mps_pkg::M_COMPLETE; r_ticks <= '0;
                                    end else begin
                                        r_raddr <= AW'(nxt);
                                        r_st <= S_ADV;
                                    end
                                end
                        endcase
                    end
                end
                S_RDN: r_st <= S_RDNW;
                S_RDNW: begin
                    r_dvd <= 27'(rd_dur); r_dvs <= 16'(per);
                    r_div_go <= 1'b1; r_st <= S_DDUR;
                end
                S_DDUR: begin
                    if (div_rsp.done) begin
                        if (r_ticks >= nt) begin
                            r_mode <= mps_pkg::M_GAP; r_ticks <= '0;
                        end
                        r_raddr <= AW'(r_pos);
                        r_st <= S_RDP;
                    end
                end
                S_ADV: r_st <= S_TONE;      // next-entry read issued
                S_RDP: r_st <= S_RDPW;
                S_RDPW: begin
                    r_en <= 1'b0; r_period <= '0;
                    r_st <= S_OUT;
                    if (r_mode == mps_pkg::M_ON && r_pos < len && rd_freq != 16'd0) begin
                        r_dvd <= r_tone_clk; r_dvs <= rd_freq;
                        r_div_go <= 1'b1; r_st <= S_DTON;
                    end
                end
                S_TONE: begin
                    // next-entry data valid: advance position
                    r_pos <= nxt;
                    r_phrase <= rd_ph;
                    r_mode <= (rd_ph != r_phrase) ? mps_pkg::M_PHRASE : mps_pkg::M_NOTE;
                    r_ticks <= '0;
                    r_raddr <= AW'(nxt);
                    r_st <= S_RDP;
                end
                S_DTON: begin
                    if (div_rsp.done) begin
                        r_en <= 1'b1; r_period <= period;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_out <= {7'd0, r_period[15:1], r_period, r_en, bank, rgb,
                                  r_phrase, r_pos, r_mode};
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_st == S_RD0))
        else $error("accept did not start sequence");
    a_tone_only_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out[25]) |-> (r_out[2:0] == mps_pkg::M_ON))
        else $error("tone outside note on");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out[9:3] <= 7'(NOTE_DEPTH)))
        else $error("position beyond song");
endmodule

>>> hdl/mps_div.sv
// ---------------------------------------------------------------------------
// mps_div
// Restoring divider, one quotient bit per cycle (27-bit by 16-bit).
// ---------------------------------------------------------------------------
module mps_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mps_pkg::t_div_req i_req,
    output mps_pkg::t_div_rsp o_rsp
);
    logic [26:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [17:0] trial;

    always_comb begin
        trial = {r_rem, r_quo[26]} - {2'b00, r_dvs};
        if (!trial[17]) begin
            n_rem = trial[16:0];
            n_quo = {r_quo[25:0], 1'b1};
        end else begin
            n_rem = {r_rem[15:0], r_quo[26]};
            n_quo = {r_quo[25:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd27;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("div done without busy");
endmodule

>>> hdl/mps_note_mem.sv
// ---------------------------------------------------------------------------
// mps_note_mem
// Note store: frequency, duration, phrase per entry; registered read.
// ---------------------------------------------------------------------------
module mps_note_mem #(
    parameter int NOTE_DEPTH = mps_pkg::NOTE_DEPTH_DEF,
    localparam int AW = $clog2(NOTE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [39:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [39:0]   o_rdata
);
    logic [39:0] r_mem [NOTE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
